// ===== sv/button_click_classifier_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define BCC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define BCC_ASSERT_NEXT(lbl, clk, ante, cons, rst_n, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define BCC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bcc_pkg.sv =====
package bcc_pkg;

    // Result codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2
    } t_click_event;

    localparam int unsigned WINDOW_WIDTH        = 8;
    localparam int unsigned EVENT_WIDTH         = 2;
    localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

    localparam logic [WINDOW_WIDTH-1:0] CLICK_WINDOW_RESET = 8'd50;

    // Pending click count codes
    localparam logic [1:0] CLICKS_NONE   = 2'd0;
    localparam logic [1:0] CLICKS_SINGLE = 2'd1;
    localparam logic [1:0] CLICKS_DOUBLE = 2'd2;
    localparam logic [1:0] CLICKS_MAX    = 2'd3;

endpackage

// ===== sv/bcc_key_if.sv =====
interface bcc_key_if;
    logic valid;
    logic ready;
    logic key_pressed;

    modport source (output valid, output key_pressed, input ready);
    modport sink   (input valid, input key_pressed, output ready);
endinterface

// ===== sv/bcc_event_if.sv =====
interface bcc_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] click_event;

    modport source (output valid, output click_event, input ready);
    modport sink   (input valid, input click_event, output ready);
endinterface

// ===== sv/button_click_classifier.sv =====
// Single/double click classifier for one button. Each request on i_key carries one
// sampled button level and yields exactly one result on o_event: 0 no click,
// 1 single click, 2 double click. A request is taken every cycle while i_key.ready
// is high; it passes through one input register and one result register to
// o_event, so up to two requests are in flight. i_key.ready drops only while both
// registers are full and o_event is stalled. The user must write the click window
// (reset 50) through i_cfg_we and i_cfg_wdata only while no request is in flight;
// the block does not enforce this. Gap and hold counters (COUNT_WIDTH bits) saturate.
module button_click_classifier #(
    parameter int unsigned COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bcc_key_if.sink                           i_key,
    bcc_event_if.source                       o_event,
    input  logic                              i_cfg_we,
    input  logic [bcc_pkg::WINDOW_WIDTH-1:0]  i_cfg_wdata
);
    import bcc_pkg::*;

    logic                    r_in_valid;
    logic                    r_key;
    logic                    r_out_valid;
    t_click_event            r_event;
    logic [WINDOW_WIDTH-1:0] r_window;
    logic                    r_latch;
    logic                    r_edge;
    logic [1:0]              r_count;
    logic [COUNT_WIDTH-1:0]  r_gap;
    logic [COUNT_WIDTH-1:0]  r_hold;

    logic                    advance;
    logic                    n_latch;
    logic                    n_edge;
    logic [1:0]              n_count;
    logic [COUNT_WIDTH-1:0]  n_gap;
    logic [COUNT_WIDTH-1:0]  n_hold;
    t_click_event            n_event;
    logic [COUNT_WIDTH-1:0]  gap_inc;
    logic [COUNT_WIDTH-1:0]  window_ext;

    // Move the held request forward when the result slot is free or drains
    assign advance        = !r_out_valid || o_event.ready;
    assign i_key.ready    = !r_in_valid || advance;
    assign o_event.valid  = r_out_valid;
    assign o_event.click_event = r_event;
    assign window_ext     = COUNT_WIDTH'(r_window);

    // Classify the held sample against the current state
    always_comb begin
        n_hold  = r_key ? ((r_hold == '1) ? r_hold : r_hold + 1'b1) : '0;
        n_latch = r_latch | r_key;
        n_edge  = r_edge;
        n_count = r_count;
        n_gap   = r_gap;
        n_event = EV_NONE;
        gap_inc = (r_gap == '1) ? r_gap : r_gap + 1'b1;

        if (!r_edge && n_latch) begin
            n_count = (r_count == CLICKS_MAX) ? r_count : r_count + 1'b1;
            n_edge  = 1'b1;
        end

        if (!r_edge && n_count == CLICKS_DOUBLE) begin
            // Second press: report at once, keep the latch as is
            n_count = CLICKS_NONE;
            n_gap   = '0;
            n_event = EV_DOUBLE;
        end else begin
            if (!r_key) begin
                n_latch = 1'b0;
                n_edge  = 1'b0;
            end
            if (n_count == CLICKS_SINGLE) begin
                n_gap = gap_inc;
                if (gap_inc > window_ext && n_hold < window_ext) begin
                    n_count = CLICKS_NONE;
                    n_gap   = '0;
                    n_event = EV_SINGLE;
                end else if (n_hold > window_ext) begin
                    // Long hold: drop the pending click silently
                    n_count = CLICKS_NONE;
                    n_gap   = '0;
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= CLICK_WINDOW_RESET;
            r_latch     <= 1'b0;
            r_edge      <= 1'b0;
            r_count     <= CLICKS_NONE;
            r_gap       <= '0;
            r_hold      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_key.ready) begin
                r_in_valid <= i_key.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && advance) begin
                r_latch <= n_latch;
                r_edge  <= n_edge;
                r_count <= n_count;
                r_gap   <= n_gap;
                r_hold  <= n_hold;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_key.ready && i_key.valid) begin
            r_key <= i_key.key_pressed;
        end
        if (r_in_valid && advance) begin
            r_event <= n_event;
        end
    end

endmodule

// ===== sv/bcc_checker.sv =====
`include "button_click_classifier_defines.svh"

module bcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_key_valid,
    input logic       i_key_ready,
    input logic       i_event_valid,
    input logic       i_event_ready,
    input logic [1:0] i_click_event
);
    import bcc_pkg::*;

    logic key_taken;

    assign key_taken = i_key_valid && i_key_ready;

    // Only the three defined result codes leave the block
    `BCC_ASSERT_IMPLY(a_event_code, i_clk, i_rst_n, i_event_valid, i_click_event == EV_NONE || i_click_event == EV_SINGLE || i_click_event == EV_DOUBLE, "bad click code")

    // An empty result slot never stalls the input
    `BCC_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !i_event_valid, i_key_ready, "input stalled with empty output")

    // Reset empties the result slot
    `BCC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_event_valid, "result after reset")

    // A stalled result holds
    `BCC_ASSERT_NEXT(a_hold_stall, i_clk, i_event_valid && !i_event_ready, i_event_valid && $stable(i_click_event), i_rst_n, "stalled result changed")

    // A request taken with the output free leaves the output valid or the input ready
    `BCC_ASSERT_NEXT(a_request_moves, i_clk, key_taken && (!i_event_valid || i_event_ready), i_event_valid || i_key_ready, i_rst_n, "request lost")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_key_valid   (i_key.valid),
    .i_key_ready   (i_key.ready),
    .i_event_valid (o_event.valid),
    .i_event_ready (o_event.ready),
    .i_click_event (o_event.click_event)
);
